@@ rtl/core/bsvs_pkg.sv @@
// Shared constants and types of the byte stream value scanner.
// No dependencies; every other file of the block imports this package.
package bsvs_pkg;

  localparam int ADDR_W      = 48;   // address bits
  localparam int MAX_PATTERN = 32;   // longest string pattern, window depth
  localparam int PAT_BYTES   = 32;   // bytes held by the pattern registers
  localparam int PLEN_W      = 6;    // width of the pattern length register
  localparam int CNT_W       = $clog2(MAX_PATTERN + 2);
  localparam int REG_IDX_W   = 3;    // configuration register index width
  localparam int CFG_DATA_W  = 64;   // configuration write data width
  localparam int QDEPTH      = 4;    // result queue entries, power of two
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // Scan modes
  localparam logic [1:0] MODE_INT    = 2'd0;
  localparam logic [1:0] MODE_FLOAT  = 2'd1;
  localparam logic [1:0] MODE_STRING = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_SCAN_MODE      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_VALUE   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_SECOND = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_THIRD  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd6;

  // One result: start address of a match and the final-result flag.
  typedef struct packed {
    logic [ADDR_W-1:0] match_address;
    logic              last_result;
  } res_t;

  // Results of one input byte, pushed into the queue together.
  typedef struct packed {
    logic [1:0] num;     // 0, 1 or 2 entries
    res_t       first;
    res_t       second;
  } push_t;

  // Head of the queue as seen by the output stage.
  typedef struct packed {
    logic valid;
    res_t entry;
  } head_t;

endpackage

@@ rtl/core/bsvs_if.sv @@
// Channel interfaces of the byte stream value scanner: input bytes,
// results and configuration writes. Depends on bsvs_pkg.
interface bsvs_in_if;
  import bsvs_pkg::*;
  logic              valid;
  logic              ready;
  logic [7:0]        data_byte;
  logic [ADDR_W-1:0] byte_address;
  logic              region_end;
  modport source(output valid, data_byte, byte_address, region_end, input ready);
  modport sink(input valid, data_byte, byte_address, region_end, output ready);
endinterface

interface bsvs_out_if;
  import bsvs_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] match_address;
  logic              last_result;
  modport source(output valid, match_address, last_result, input ready);
  modport sink(input valid, match_address, last_result, output ready);
endinterface

interface bsvs_cfg_if;
  import bsvs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;
  modport source(output valid, reg_index, wr_data, input ready);
  modport sink(input valid, reg_index, wr_data, output ready);
endinterface

@@ rtl/core/bsvs_front.sv @@
// Front end: configuration registers, byte window and match detection.
// Depends on bsvs_pkg and the channel interfaces in bsvs_if.sv.
module bsvs_front (
  input  logic                   clk,
  input  logic                   rst_n,
  bsvs_in_if.sink                in_chan,
  bsvs_cfg_if.sink               cfg_chan,
  input  logic                   space_ok,
  output bsvs_pkg::push_t        push
);
  import bsvs_pkg::*;

  function automatic logic is_nan(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  logic [1:0]              scan_mode_r;
  logic [31:0]             target_value_r;
  logic [PLEN_W-1:0]       pattern_length_r;
  logic [PAT_BYTES*8-1:0]  pattern_r;

  logic [7:0]              win_r [MAX_PATTERN];
  logic [CNT_W-1:0]        held_r;
  logic [CNT_W-1:0]        held_nxt;

  logic                    accept;
  logic [7:0]              win_new [MAX_PATTERN];
  logic [CNT_W-1:0]        eff_len;
  logic [CNT_W-1:0]        shift_bytes;
  logic [MAX_PATTERN*8-1:0] pat_ext;
  logic [MAX_PATTERN*8-1:0] pat_rev;
  logic [MAX_PATTERN*8-1:0] pat_align;
  logic [MAX_PATTERN-1:0]  ok_end;
  logic [MAX_PATTERN-1:0]  ok_zero;
  logic                    hit_end;
  logic                    hit_zero;
  logic [31:0]             word;
  logic                    hit_word;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = space_ok;
  assign accept         = in_chan.valid && space_ok;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_mode_r      <= MODE_INT;
      target_value_r   <= '0;
      pattern_length_r <= PLEN_W'(1);
      pattern_r        <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.reg_index)
        REG_SCAN_MODE:      scan_mode_r      <= cfg_chan.wr_data[1:0];
        REG_TARGET_VALUE:   target_value_r   <= cfg_chan.wr_data[31:0];
        REG_PATTERN_LENGTH: pattern_length_r <= cfg_chan.wr_data[PLEN_W-1:0];
        REG_PATTERN_LOW:    pattern_r[0*64 +: 64] <= cfg_chan.wr_data;
        REG_PATTERN_SECOND: pattern_r[1*64 +: 64] <= cfg_chan.wr_data;
        REG_PATTERN_THIRD:  pattern_r[2*64 +: 64] <= cfg_chan.wr_data;
        REG_PATTERN_HIGH:   pattern_r[3*64 +: 64] <= cfg_chan.wr_data;
        default: ;
      endcase
    end
  end

  // Window after this byte enters: slot 0 is the newest byte.
  always_comb begin
    win_new[0] = in_chan.data_byte;
    for (int t = 1; t < MAX_PATTERN; t++) begin
      win_new[t] = win_r[t-1];
    end
  end

  assign held_nxt = (held_r < CNT_W'(MAX_PATTERN + 1)) ? held_r + CNT_W'(1) : held_r;

  // Stale window bytes are never compared: every hit is gated by the fill count.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int t = 0; t < MAX_PATTERN; t++) begin
        win_r[t] <= win_new[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (accept) begin
      held_r <= in_chan.region_end ? '0 : held_nxt;
    end
  end

  // Clamp the pattern length to 1..MAX_PATTERN.
  always_comb begin
    if (pattern_length_r == '0) begin
      eff_len = CNT_W'(1);
    end else if (CNT_W'(pattern_length_r) > CNT_W'(MAX_PATTERN)) begin
      eff_len = CNT_W'(MAX_PATTERN);
    end else begin
      eff_len = CNT_W'(pattern_length_r);
    end
  end

  // Align the pattern so that window slot t meets pattern byte len-1-t.
  assign pat_ext     = (MAX_PATTERN*8)'(pattern_r);
  assign shift_bytes = CNT_W'(MAX_PATTERN) - eff_len;

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pat_rev[k*8 +: 8] = pat_ext[(MAX_PATTERN-1-k)*8 +: 8];
    end
  end

  assign pat_align = pat_rev >> {shift_bytes, 3'b000};

  always_comb begin
    for (int t = 0; t < MAX_PATTERN; t++) begin
      ok_end[t]  = (CNT_W'(t) >= eff_len) || (win_new[t] == pat_align[t*8 +: 8]);
      ok_zero[t] = (CNT_W'(t) >= eff_len) || (win_r[t] == pat_align[t*8 +: 8]);
    end
  end

  // Pattern ending at this byte on the last byte of a region, and pattern
  // ending at the previous byte confirmed by a zero terminator.
  assign hit_end  = in_chan.region_end && (&ok_end) && (held_nxt >= eff_len);
  assign hit_zero = (in_chan.data_byte == 8'd0) && (&ok_zero) &&
                    (held_nxt >= eff_len + CNT_W'(1));

  assign word = {win_new[0], win_new[1], win_new[2], win_new[3]};

  always_comb begin
    hit_word = 1'b0;
    case (scan_mode_r)
      MODE_INT:   hit_word = (word == target_value_r);
      MODE_FLOAT: hit_word = !is_nan(word) && !is_nan(target_value_r) &&
                             (((word[30:0] == '0) && (target_value_r[30:0] == '0)) ||
                              (word == target_value_r));
      default:    hit_word = 1'b0;
    endcase
    if (held_nxt < CNT_W'(4)) begin
      hit_word = 1'b0;
    end
  end

  always_comb begin
    push        = '0;
    push.second = '0;
    if (accept) begin
      case (scan_mode_r)
        MODE_INT, MODE_FLOAT: begin
          if (hit_word) begin
            push.num   = 2'd1;
            push.first = '{match_address: in_chan.byte_address - ADDR_W'(3),
                           last_result: 1'b1};
          end
        end
        MODE_STRING: begin
          if (hit_zero) begin
            push.num   = 2'd1;
            push.first = '{match_address: in_chan.byte_address - ADDR_W'(eff_len),
                           last_result: !hit_end};
            if (hit_end) begin
              push.num    = 2'd2;
              push.second = '{match_address: in_chan.byte_address -
                                             ADDR_W'(eff_len - CNT_W'(1)),
                              last_result: 1'b1};
            end
          end else if (hit_end) begin
            push.num   = 2'd1;
            push.first = '{match_address: in_chan.byte_address -
                                          ADDR_W'(eff_len - CNT_W'(1)),
                           last_result: 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/bsvs_queue.sv @@
// Result queue between the match front end and the output stage.
// Takes up to two results a cycle, gives one. Depends on bsvs_pkg.
module bsvs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  bsvs_pkg::push_t  push,
  output logic             space_ok,
  input  logic             pop,
  output bsvs_pkg::head_t  head
);
  import bsvs_pkg::*;

  res_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] wptr_nxt;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  // Room for the worst case of one byte: two results.
  assign space_ok   = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign head.valid = (cnt_r != '0);
  assign head.entry = mem[rptr_r];

  assign wptr_nxt = wptr_r + QPTR_W'(push.num);
  assign cnt_nxt  = cnt_r + QCNT_W'(push.num) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wptr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem[wptr_r + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      cnt_r  <= cnt_nxt;
      if (pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/bsvs_back.sv @@
// Output stage: registers the queue head onto the result channel.
// Depends on bsvs_pkg and bsvs_out_if.
module bsvs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  bsvs_pkg::head_t  head,
  output logic             pop,
  bsvs_out_if.source       out_chan
);
  import bsvs_pkg::*;

  logic valid_r;
  res_t data_r;

  // Advance when the register is empty or being taken.
  assign pop = head.valid && (!valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= head.entry;
    end
  end

  assign out_chan.valid         = valid_r;
  assign out_chan.match_address = data_r.match_address;
  assign out_chan.last_result   = data_r.last_result;

endmodule

@@ rtl/core/byte_stream_value_scanner.sv @@
// Top level of the byte stream value scanner: front end, result queue and
// output stage. Depends on bsvs_pkg, bsvs_if.sv, bsvs_front, bsvs_queue, bsvs_back.
//
//   channel    dir  transaction
//   in_chan    in   data_byte, byte_address, region_end: one byte of the region
//   out_chan   out  match_address, last_result: one match start address
//   cfg_chan   in   reg_index, wr_data: one configuration register write
//
// Cycles: one byte per cycle sustained while the result queue has room; a byte
// is classified in the cycle it is accepted, and its results pass through the
// four-entry result queue and the output register to out_chan. A string byte
// with two matches gives two results; the single output register sends them in turn.
// Reset: synchronous, active low, clears the configuration, the window fill
// count, the queue pointers and the output valid; no clearing pass.
// Stalls: in_chan is held off while fewer than two queue entries are free.
module byte_stream_value_scanner (
  input  logic       clk,
  input  logic       rst_n,
  bsvs_in_if.sink    in_chan,
  bsvs_out_if.source out_chan,
  bsvs_cfg_if.sink   cfg_chan
);
  import bsvs_pkg::*;

  push_t push;
  head_t head;
  logic  space_ok;
  logic  pop;

  // Front end: take bytes, slide the window, find matches.
  bsvs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .space_ok (space_ok),
    .push     (push)
  );

  // Queue: decouple match detection from the result consumer.
  bsvs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .pop      (pop),
    .head     (head)
  );

  // Back end: hold each result until the consumer takes it.
  bsvs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

@@ tb/tb_byte_stream_value_scanner.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of byte_stream_value_scanner: directed and random byte regions,
// predicted match addresses, random stalls on both channels. Depends on bsvs_pkg and bsvs_if.sv.
module tb_byte_stream_value_scanner;
  import bsvs_pkg::*;

  localparam int WIN_DEPTH      = MAX_PATTERN + 1;
  localparam int IDLE_PCT       = 13;    // chance of an idle cycle on either side
  localparam int RANDOM_ITEMS   = 650;
  localparam int SETTLE_CYCLES  = 6;     // margin for the pipe to settle
  localparam int HOLD_OFF_LEN   = 150;   // long receiver stall of the pressure test
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction at all
  localparam int DRAIN_LIMIT    = 2000;

  logic clk;
  logic rst_n;

  bsvs_in_if  in_chan();
  bsvs_out_if out_chan();
  bsvs_cfg_if cfg_chan();

  byte_stream_value_scanner u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Mirror of the block: configuration, byte window and its fill count
  logic [1:0]  cfg_mode;
  logic [31:0] cfg_target;
  logic [5:0]  cfg_plen;
  logic [63:0] cfg_pattern [4];
  logic [7:0]  recent_bytes [WIN_DEPTH];
  int          recent_count;

  // Match results still owed by the block, oldest first
  res_t expected_matches[$];

  bit steady;         // set: neither side idles
  int hold_off_req;   // receiver stall length requested by a test

  int mismatches;
  int bytes_sent;
  int regions_sent;
  int results_checked;
  int config_phases;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pattern_byte(int j);
    return cfg_pattern[j >> 3][(j & 7) * 8 +: 8];
  endfunction

  // Length 0 acts as 1, anything past the window acts as the full pattern
  function automatic int eff_plen();
    if (cfg_plen == 0) return 1;
    if (cfg_plen > MAX_PATTERN) return MAX_PATTERN;
    return int'(cfg_plen);
  endfunction

  // Pattern whose last byte sits in window slot off; pattern byte 0 is the oldest
  function automatic bit pattern_ends_at(int off, int len);
    if (recent_count < off + len) return 1'b0;
    for (int j = 0; j < len; j++) begin
      if (recent_bytes[off + len - 1 - j] != pattern_byte(j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit is_nan(logic [31:0] w);
    return (w[30:23] == 8'hFF) && (w[22:0] != 0);
  endfunction

  // Advance the window by one accepted byte and queue the matches it reports
  function automatic void scan_byte(logic [7:0] b, logic [ADDR_W-1:0] addr, bit last);
    res_t        found [2];
    int          n;
    int          len;
    logic [31:0] word;
    bit          hit;
    n = 0;
    for (int i = WIN_DEPTH - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
    recent_bytes[0] = b;
    if (recent_count < WIN_DEPTH) recent_count++;

    if ((cfg_mode == MODE_INT || cfg_mode == MODE_FLOAT) && recent_count >= 4) begin
      word = {recent_bytes[0], recent_bytes[1], recent_bytes[2], recent_bytes[3]};
      if (cfg_mode == MODE_INT) hit = (word == cfg_target);
      else if (is_nan(word) || is_nan(cfg_target)) hit = 1'b0;
      else if (word[30:0] == 0 && cfg_target[30:0] == 0) hit = 1'b1;
      else hit = (word == cfg_target);
      if (hit) begin
        found[n].match_address = addr - ADDR_W'(3);
        n++;
      end
    end else if (cfg_mode == MODE_STRING) begin
      len = eff_plen();
      // zero terminator confirms a pattern ending just before it
      if (b == 8'h00 && pattern_ends_at(1, len)) begin
        found[n].match_address = addr - ADDR_W'(len);
        n++;
      end
      // end of region confirms a pattern ending on this byte
      if (last && pattern_ends_at(0, len)) begin
        found[n].match_address = addr - ADDR_W'(len - 1);
        n++;
      end
    end

    for (int k = 0; k < n; k++) begin
      found[k].last_result = (k == n - 1);
      expected_matches.insert(expected_matches.size(), found[k]);
    end
    if (last) begin
      foreach (recent_bytes[i]) recent_bytes[i] = 8'h00;
      recent_count = 0;
    end
  endfunction

  function automatic void apply_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SCAN_MODE:      cfg_mode = data[1:0];
      REG_TARGET_VALUE:   cfg_target = data[31:0];
      REG_PATTERN_LENGTH: cfg_plen = data[5:0];
      REG_PATTERN_LOW:    cfg_pattern[0] = data;
      REG_PATTERN_SECOND: cfg_pattern[1] = data;
      REG_PATTERN_THIRD:  cfg_pattern[2] = data;
      REG_PATTERN_HIGH:   cfg_pattern[3] = data;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one byte; predict its matches at the edge that takes it
  task automatic offer_byte(logic [7:0] b, logic [ADDR_W-1:0] addr, bit last);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.data_byte    <= b;
    in_chan.byte_address <= addr;
    in_chan.region_end   <= last;
    do @(posedge clk); while (!in_chan.ready);
    scan_byte(b, addr, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send a whole region in address order; the last byte closes it
  task automatic stream_region(logic [7:0] q[$], logic [ADDR_W-1:0] base, bit gaps);
    logic [ADDR_W-1:0] a;
    a = base;
    foreach (q[i]) begin
      offer_byte(q[i], a, i == q.size() - 1);
      a = a + ADDR_W'(1);
      if (gaps && $urandom_range(99) < 5) a = a + ADDR_W'($urandom_range(1, 4000));
    end
    regions_sent++;
  endtask

  // Hold the input, let every owed result arrive, then let the pipe settle
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (expected_matches.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_chan.valid     <= 1'b1;
    cfg_chan.reg_index <= idx;
    cfg_chan.wr_data   <= data;
    do @(posedge clk); while (!cfg_chan.ready);
    apply_reg(idx, data);
    @(negedge clk);
  endtask

  // Write every register while the block is idle
  task automatic configure(logic [1:0] mode, logic [31:0] target, logic [5:0] plen,
                           logic [255:0] pat);
    wait_idle();
    write_reg(REG_SCAN_MODE, CFG_DATA_W'(mode));
    write_reg(REG_TARGET_VALUE, CFG_DATA_W'(target));
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(plen));
    write_reg(REG_PATTERN_LOW, pat[63:0]);
    write_reg(REG_PATTERN_SECOND, pat[127:64]);
    write_reg(REG_PATTERN_THIRD, pat[191:128]);
    write_reg(REG_PATTERN_HIGH, pat[255:192]);
    cfg_chan.valid <= 1'b0;
    config_phases++;
  endtask

  // ---------------------------------------------------------------------------
  // Random stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [ADDR_W-1:0] random_base();
    if ($urandom_range(99) < 10) return '1 - ADDR_W'($urandom_range(0, 20));
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  // Background byte: zeros, pieces of the target or pattern, or anything
  function automatic logic [7:0] filler_byte();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 8'h00;
    if (r < 55) begin
      if (cfg_mode == MODE_STRING) return pattern_byte($urandom_range(eff_plen() - 1));
      return cfg_target[8 * $urandom_range(3) +: 8];
    end
    return 8'($urandom());
  endfunction

  // Plant a value that should match; now and then break it off early
  function automatic void plant_value(ref logic [7:0] q[$], input bit allow_tail);
    logic [31:0] w;
    int          n;
    int          len;
    int          r;
    if (cfg_mode == MODE_STRING) begin
      len = eff_plen();
      n = ($urandom_range(99) < 20) ? $urandom_range(len - 1) : len;
      for (int j = 0; j < n; j++) q.insert(q.size(), pattern_byte(j));
      if (allow_tail && $urandom_range(99) < 70) q.insert(q.size(), 8'h00);
    end else begin
      w = cfg_target;
      r = $urandom_range(99);
      if (cfg_mode == MODE_FLOAT) begin
        if (r < 15) w = 32'h7F80_0000 | 32'($urandom_range(1, 32'h7F_FFFF)) |
                        (32'($urandom_range(1)) << 31);
        else if (r < 50 && cfg_target[30:0] == 0) w = cfg_target ^ 32'h8000_0000;
      end
      n = ($urandom_range(99) < 15) ? $urandom_range(1, 3) : 4;
      for (int k = 0; k < n; k++) q.insert(q.size(), w[8*k +: 8]);
    end
  endfunction

  task automatic stream_random_region();
    logic [7:0] q[$];
    int         n;
    n = ($urandom_range(99) < 25) ? $urandom_range(1, 3) : $urandom_range(4, 48);
    while (q.size() < n) begin
      if ($urandom_range(99) < 30) plant_value(q, 1'b1);
      else q.insert(q.size(), filler_byte());
    end
    // end some regions right on a planted value
    if ($urandom_range(99) < 40) plant_value(q, 1'b0);
    stream_region(q, random_base(), $urandom_range(99) < 30);
  endtask

  // Pick a setting; the first phases pin the extremes
  task automatic random_config(int phase);
    logic [1:0]   mode;
    logic [31:0]  target;
    logic [5:0]   plen;
    logic [255:0] pat;
    int           r;
    r = $urandom_range(99);
    mode = (r < 30) ? MODE_INT : (r < 55) ? MODE_FLOAT : (r < 90) ? MODE_STRING : MODE_UNUSED;
    r = $urandom_range(99);
    if (mode == MODE_FLOAT) begin
      if (r < 30) target = 32'($urandom_range(1)) << 31;
      else if (r < 45) target = 32'h7F80_0000 | 32'($urandom_range(1, 32'h7F_FFFF));
      else if (r < 55) target = ($urandom_range(1) != 0) ? 32'hFF80_0000 : 32'h7F80_0000;
      else target = $urandom();
    end else begin
      target = (r < 20) ? 32'h0 : (r < 30) ? 32'hFFFF_FFFF : 32'($urandom());
    end
    r = $urandom_range(99);
    if (r < 70) plen = 6'($urandom_range(1, 8));
    else begin
      case ($urandom_range(4))
        0: plen = 6'd0;
        1: plen = 6'd32;
        2: plen = 6'd33;
        3: plen = 6'd63;
        default: plen = 6'($urandom_range(63));
      endcase
    end
    // small alphabet so that partial matches overlap
    for (int k = 0; k < PAT_BYTES; k++) begin
      r = $urandom_range(99);
      pat[8*k +: 8] = (r < 45) ? 8'h61 : (r < 80) ? 8'h62 :
                      (r < 95) ? 8'($urandom_range(1, 255)) : 8'h00;
    end
    case (phase)
      0: begin
        mode = MODE_STRING;
        plen = 6'd63;
        pat  = '1;
      end
      1: begin
        mode   = MODE_FLOAT;
        target = 32'h8000_0000;
      end
      2: begin
        mode   = MODE_INT;
        target = 32'hFFFF_FFFF;
      end
      3: mode = MODE_UNUSED;
      default: ;
    endcase
    configure(mode, target, plen, pat);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset setting is integer mode, target zero; the region wraps past the top address
  task automatic test_reset_defaults();
    logic [7:0] q[$];
    q = {8'h00, 8'h00, 8'h00, 8'h00};
    stream_region(q, 48'hFFFF_FFFF_FFFE, 1'b0);
  endtask

  // A short region never matches; a full word of all-ones does
  task automatic test_word_match();
    logic [7:0] q[$];
    configure(MODE_INT, 32'hFFFF_FFFF, 6'd1, '0);
    q = {8'hFF, 8'hFF, 8'hFF};
    stream_region(q, 48'h0000_0000_1000, 1'b0);
    q = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
    stream_region(q, 48'h8000_0000_0000, 1'b0);
  endtask

  // Minus zero equals plus zero; a NaN target matches nothing, itself included
  task automatic test_float_match();
    logic [7:0] q[$];
    configure(MODE_FLOAT, 32'h0, 6'd1, '0);
    q = {8'h00, 8'h00, 8'h00, 8'h80};
    stream_region(q, 48'h0000_2000_0000, 1'b0);
    configure(MODE_FLOAT, 32'h7FC0_0000, 6'd1, '0);
    q = {8'h00, 8'h00, 8'hC0, 8'h7F};
    stream_region(q, 48'h0000_2000_0100, 1'b0);
  endtask

  // Zero terminator and region end on one byte; pattern length 0 acts as 1
  task automatic test_string_match();
    logic [7:0] q[$];
    configure(MODE_STRING, 32'h0, 6'd2, '0);
    q = {8'h00, 8'h00, 8'h00};
    stream_region(q, 48'h0000_0300_0000, 1'b0);
    configure(MODE_STRING, 32'h0, 6'd0, 256'h41);
    q = {8'h41, 8'h00};
    stream_region(q, 48'h0000_0300_0040, 1'b0);
  endtask

  // Mode 3 reports nothing even where mode 0 would
  task automatic test_unused_mode();
    logic [7:0] q[$];
    configure(MODE_UNUSED, 32'h0, 6'd1, '0);
    q = {8'h00, 8'h00, 8'h00, 8'h00};
    stream_region(q, 48'h0000_0000_4000, 1'b0);
  endtask

  // Stall the receiver long while every byte from the fourth on matches: the queue fills, input stalls
  task automatic test_backpressure();
    logic [7:0] q[$];
    configure(MODE_INT, 32'h0, 6'd1, '0);
    for (int i = 0; i < 40; i++) q.insert(q.size(), 8'h00);
    hold_off_req = HOLD_OFF_LEN;
    stream_region(q, random_base(), 1'b0);
  endtask

  task automatic test_random_scan();
    int start;
    int phase_start;
    int phase;
    start = bytes_sent;
    phase = 0;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      random_config(phase);
      steady = (phase == 4);  // one stretch without any idling
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 70) stream_random_region();
      steady = 1'b0;
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req > 0) begin
        stall_left   = hold_off_req;
        hold_off_req = 0;
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic void log_mismatch(string what, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected addr=%h last=%0b, got addr=%h last=%0b", $time, what,
               want.match_address, want.last_result, got.match_address, got.last_result);
  endfunction

  // Compare every result transaction with the oldest owed match
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.match_address = out_chan.match_address;
      got.last_result   = out_chan.last_result;
      results_checked++;
      if (expected_matches.size() == 0) begin
        log_mismatch("result with nothing pending", '0, got);
      end else begin
        want = expected_matches.pop_front();
        if (got.match_address !== want.match_address || got.last_result !== want.last_result)
          log_mismatch("result mismatch", want, got);
      end
    end
  end

  // Abort when no transaction of any kind happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transaction for %0d cycles, %0d results still owed",
             WATCHDOG_LIMIT, expected_matches.size());
    $display("tb_byte_stream_value_scanner: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.data_byte    = 8'h00;
    in_chan.byte_address = '0;
    in_chan.region_end   = 1'b0;
    cfg_chan.valid       = 1'b0;
    cfg_chan.reg_index   = '0;
    cfg_chan.wr_data     = '0;
    steady               = 1'b0;
    hold_off_req         = 0;
    mismatches           = 0;
    bytes_sent           = 0;
    regions_sent         = 0;
    results_checked      = 0;
    config_phases        = 0;

    // mirror the reset state
    cfg_mode   = MODE_INT;
    cfg_target = 32'h0;
    cfg_plen   = 6'd1;
    foreach (cfg_pattern[i]) cfg_pattern[i] = '0;
    foreach (recent_bytes[i]) recent_bytes[i] = 8'h00;
    recent_count = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_word_match();
    test_float_match();
    test_string_match();
    test_unused_mode();
    test_backpressure();
    test_random_scan();

    // drain, bounded so that a lost result is reported here
    in_chan.valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && expected_matches.size() != 0; n++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_matches.size() != 0) begin
      $display("%0d expected results never arrived", expected_matches.size());
      mismatches += expected_matches.size();
    end

    $display("Scanned %0d bytes in %0d regions under %0d register settings, %0d matches checked",
             bytes_sent, regions_sent, config_phases, results_checked);
    $display("Modes: integer, float, string, unused; lengths 0 to 63; one long output stall");
    if (mismatches == 0) begin
      $display("tb_byte_stream_value_scanner: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_byte_stream_value_scanner: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/bsvs_pkg.sv
rtl/core/bsvs_if.sv
rtl/core/bsvs_front.sv
rtl/core/bsvs_queue.sv
rtl/core/bsvs_back.sv
rtl/core/byte_stream_value_scanner.sv
tb/tb_byte_stream_value_scanner.sv
